// ===== hdl/rist_pkg.sv =====
package rist_pkg;

    localparam int SLOTS      = 32;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int INUM_BITS  = 15;
    localparam int COUNT_BITS = 8;

    localparam int MODE_BITS     = 2;
    localparam int IN_SLOT_BITS  = 5;
    localparam int STATUS_BITS   = 3;
    localparam int OUT_SLOT_BITS = 5;
    localparam int OUT_CNT_BITS  = 8;
    localparam int OUT_INUM_BITS = 15;

    localparam logic [MODE_BITS-1:0] MODE_GET   = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_PUT   = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR = 2'd2;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_HIT     = 3'd0,
        ST_MISS    = 3'd1,
        ST_NOFREE  = 3'd2,
        ST_PUT     = 3'd3,
        ST_PUTIGN  = 3'd4,
        ST_CLEARED = 3'd5,
        ST_FULL    = 3'd6
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MATCH,
        S_EXEC
    } t_state;

    typedef struct packed {
        logic [MODE_BITS-1:0]    mode;
        logic [INUM_BITS-1:0]    inode_number;
        logic [IN_SLOT_BITS-1:0] slot_index;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_BITS-1:0]   status;
        logic [OUT_SLOT_BITS-1:0] granted_slot;
        logic [OUT_CNT_BITS-1:0]  count_after;
        logic [OUT_INUM_BITS-1:0] slot_inode_number;
        logic                     load_needed;
        logic                     writeback_needed;
    } t_out_item;

    typedef struct packed {
        logic load_in;
        logic capture;
        logic execute;
    } t_dp_cmd;

    typedef struct packed {
        logic out_valid;
    } t_dp_status;

endpackage

// ===== hdl/refcounted_inode_slot_table.sv =====
// channel   signals                              direction
// input     i_in_valid, o_in_stall, i_in_item    into the block
// output    o_out_valid, i_out_stall, o_out_item out of the block
//
// each item takes two steps: one to match the inode number against every
// slot and flag free slots, one to pick the lowest slot and update its count
// a new item is taken in the update cycle whenever the output register is free
// reset empties the table (all counts and inode numbers zero)
// a stalled output holds the block in its update cycle until the item leaves
module refcounted_inode_slot_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  rist_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output rist_pkg::t_out_item o_out_item
);
    import rist_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status sts;

    rist_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_in_stall  (o_in_stall),
        .o_cmd       (cmd)
    );

    rist_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_in_item   (i_in_item),
        .i_out_stall (i_out_stall),
        .o_sts       (sts),
        .o_out_item  (o_out_item)
    );

    assign o_out_valid = sts.out_valid;

endmodule

// ===== hdl/rist_ctrl.sv =====
module rist_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_out_stall,
    input  rist_pkg::t_dp_status i_sts,
    output logic                o_in_stall,
    output rist_pkg::t_dp_cmd   o_cmd
);
    import rist_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   out_free;
    logic   take_in;

    assign out_free = !i_sts.out_valid || !i_out_stall;
    assign take_in  = (r_state == S_IDLE) || ((r_state == S_EXEC) && out_free);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_MATCH;
            end
            S_MATCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                if (out_free) n_state = i_in_valid ? S_MATCH : S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall    = !take_in;
        o_cmd.load_in = take_in && i_in_valid;
        o_cmd.capture = (r_state == S_MATCH);
        o_cmd.execute = (r_state == S_EXEC) && out_free;
    end

endmodule

// ===== hdl/rist_datapath.sv =====
module rist_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rist_pkg::t_dp_cmd    i_cmd,
    input  rist_pkg::t_in_item   i_in_item,
    input  logic                 i_out_stall,
    output rist_pkg::t_dp_status o_sts,
    output rist_pkg::t_out_item  o_out_item
);
    import rist_pkg::*;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    logic [INUM_BITS-1:0]    r_inode [SLOTS];
    logic [COUNT_BITS-1:0]   r_refs  [SLOTS];

    logic [MODE_BITS-1:0]    r_mode;
    logic [INUM_BITS-1:0]    r_inum;
    logic [IN_SLOT_BITS-1:0] r_idx;

    logic [SLOTS-1:0]        r_hit_vec;
    logic [SLOTS-1:0]        r_free_vec;

    t_out_item               r_out;
    logic                    r_out_valid;
    t_out_item               n_out;

    logic                    hit_any;
    logic [SLOT_BITS-1:0]    hit_idx;
    logic                    free_any;
    logic [SLOT_BITS-1:0]    free_idx;

    logic                    put_in_range;
    logic [SLOT_BITS-1:0]    put_idx;
    logic [COUNT_BITS-1:0]   hit_cnt;
    logic [COUNT_BITS-1:0]   put_cnt;

    logic                    wr_refs_en;
    logic [SLOT_BITS-1:0]    wr_idx;
    logic [COUNT_BITS-1:0]   wr_refs;
    logic                    wr_inode_en;
    logic                    clear_all;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode <= i_in_item.mode;
            r_inum <= i_in_item.inode_number;
            r_idx  <= i_in_item.slot_index;
        end
    end

    // associative match and free flags over all slots
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_hit_vec[i]  <= (r_refs[i] != '0) && (r_inode[i] == r_inum);
                r_free_vec[i] <= (r_refs[i] == '0);
            end
        end
    end

    // lowest set bit wins
    always_comb begin
        hit_any  = 1'b0;
        hit_idx  = '0;
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (r_hit_vec[i]) begin
                hit_any = 1'b1;
                hit_idx = SLOT_BITS'(i);
            end
            if (r_free_vec[i]) begin
                free_any = 1'b1;
                free_idx = SLOT_BITS'(i);
            end
        end
    end

    assign put_in_range = (int'(r_idx) < SLOTS);
    assign put_idx      = SLOT_BITS'(r_idx);
    assign hit_cnt      = r_refs[hit_idx];
    assign put_cnt      = r_refs[put_idx];

    always_comb begin
        n_out       = '0;
        wr_refs_en  = 1'b0;
        wr_idx      = '0;
        wr_refs     = '0;
        wr_inode_en = 1'b0;
        clear_all   = 1'b0;
        n_out.status = ST_PUTIGN;
        unique case (r_mode)
            MODE_GET: begin
                if (hit_any) begin
                    n_out.granted_slot      = OUT_SLOT_BITS'(hit_idx);
                    n_out.slot_inode_number = OUT_INUM_BITS'(r_inode[hit_idx]);
                    if (hit_cnt == COUNT_MAX) begin
                        n_out.status      = ST_FULL;
                        n_out.count_after = OUT_CNT_BITS'(hit_cnt);
                    end else begin
                        n_out.status      = ST_HIT;
                        n_out.count_after = OUT_CNT_BITS'(hit_cnt + 1'b1);
                        wr_refs_en        = 1'b1;
                        wr_idx            = hit_idx;
                        wr_refs           = hit_cnt + 1'b1;
                    end
                end else if (free_any) begin
                    n_out.status            = ST_MISS;
                    n_out.granted_slot      = OUT_SLOT_BITS'(free_idx);
                    n_out.count_after       = OUT_CNT_BITS'(1);
                    n_out.slot_inode_number = OUT_INUM_BITS'(r_inum);
                    n_out.load_needed       = 1'b1;
                    wr_refs_en              = 1'b1;
                    wr_inode_en             = 1'b1;
                    wr_idx                  = free_idx;
                    wr_refs                 = COUNT_BITS'(1);
                end else begin
                    n_out.status = ST_NOFREE;
                end
            end
            MODE_PUT: begin
                n_out.granted_slot = OUT_SLOT_BITS'(r_idx);
                if (!put_in_range) begin
                    n_out.status = ST_PUTIGN;
                end else if (put_cnt == '0) begin
                    n_out.status            = ST_PUTIGN;
                    n_out.slot_inode_number = OUT_INUM_BITS'(r_inode[put_idx]);
                end else begin
                    n_out.status            = ST_PUT;
                    n_out.count_after       = OUT_CNT_BITS'(put_cnt - 1'b1);
                    n_out.slot_inode_number = OUT_INUM_BITS'(r_inode[put_idx]);
                    n_out.writeback_needed  = 1'b1;
                    wr_refs_en              = 1'b1;
                    wr_idx                  = put_idx;
                    wr_refs                 = put_cnt - 1'b1;
                end
            end
            MODE_CLEAR: begin
                n_out.status = ST_CLEARED;
                clear_all    = 1'b1;
            end
            default: begin
                n_out.status = ST_PUTIGN;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_refs[i]  <= '0;
                r_inode[i] <= '0;
            end
        end else if (i_cmd.execute) begin
            if (clear_all) begin
                for (int i = 0; i < SLOTS; i++) begin
                    r_refs[i] <= '0;
                end
            end else begin
                if (wr_refs_en) r_refs[wr_idx] <= wr_refs;
                if (wr_inode_en) r_inode[wr_idx] <= r_inum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.execute) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.execute) begin
            r_out <= n_out;
        end
    end

    assign o_sts.out_valid = r_out_valid;
    assign o_out_item      = r_out;

endmodule
